### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that pre implies post in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Check that pre implies post in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int FIELD_BITS    = 32;
  localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
  localparam int OUT_DATA_BITS = 2 * FIELD_BITS;
  localparam int OUT_USER_BITS = 3;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_GT  = 3'd4,
    OP_LT  = 3'd5,
    OP_EQ  = 3'd6,
    OP_NE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_Q,
    S_MUL_D,
    S_GCD_GO,
    S_GCD_WAIT,
    S_DIVN_GO,
    S_DIVN_WAIT,
    S_DIVD_GO,
    S_DIVD_WAIT,
    S_OUT
  } fsm_t;

endpackage
`default_nettype wire

### design/rau_gcd.sv
`default_nettype none
module rau_gcd #(
  parameter int PW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [PW-1:0] a_in,
  input  wire logic [PW-1:0] b_in,
  output logic               done,
  output logic [PW-1:0]      gcd
);

  localparam int KW = $clog2(PW);

  logic [PW-1:0] a_r, a_nxt, b_r, b_nxt, g_r, g_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  // One binary gcd step per cycle: shared factor, lone even halving, or subtract
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_in;
      b_nxt    = b_in;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (a_r == '0 || b_r == '0) begin
        g_nxt    = (a_r | b_r) << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r > b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
  end

  assign done = done_r;
  assign gcd  = g_r;

endmodule
`default_nettype wire

### design/rau_div.sv
`default_nettype none
module rau_div #(
  parameter int PW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [PW-1:0] dividend,
  input  wire logic [PW-1:0] divisor,
  output logic               done,
  output logic [PW-1:0]      quotient
);

  localparam int CW = $clog2(PW) + 1;

  logic [PW:0]   rem_r, rem_nxt, rem_sh, diff;
  logic [PW-1:0] quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  assign rem_sh = {rem_r[PW-1:0], quo_r[PW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(PW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[PW]) begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[PW-2:0], 1'b0};
      end else begin
        rem_nxt = diff;
        quo_nxt = {quo_r[PW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### design/rational_arithmetic_unit.sv
// Rational arithmetic unit: combines two signed fractions under one of eight ops.
// Input channel in_*: one beat per operation; in_tuser carries the op code,
// in_tdata the four operand words. Output channel out_*: one beat per input
// beat, reduced numerator and positive denominator in out_tdata, the compare
// outcome and a status code in out_tuser.
// Arithmetic results are built from exact cross products formed on one shared
// multiplier (one product per cycle), then reduced by an iterative binary gcd
// (one step per cycle) and two restoring divisions by the gcd. Compares end
// after the two cross products and go to the result beat; operand errors go
// from the accepted beat straight to the result beat.
// One item is in flight at a time: in_tready is high only while idle, so the
// next beat can be taken at the earliest in the cycle after the result beat.
// in_tready stays low while a finished result waits on a stalled receiver.
// Reset (rst_n low, synchronous) returns the block to idle with no result
// pending.
`default_nettype none
`include "assert_macros.svh"
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // lhs_num, lhs_den, rhs_num, rhs_den from the lowest bit up
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,
  // op
  input  wire logic [2:0]               in_tuser,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // res_num, res_den from the lowest bit up
  output logic [OUT_DATA_BITS-1:0]      out_tdata,
  // truth, status from the lowest bit up
  output logic [OUT_USER_BITS-1:0]      out_tuser
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;

  fsm_t          state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [W-1:0]  an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [PW-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [PW-1:0] nmag_r, nmag_nxt, dmag_r, dmag_nxt;
  logic          nneg_r, nneg_nxt, truth_r, truth_nxt, err_r, err_nxt;

  logic [W-1:0]  in_an, in_ad, in_bn, in_bd;
  logic [W-1:0]  an_m, ad_m, bn_m, bd_m, mul_a, mul_b;
  logic [PW-1:0] mul_y;
  logic          sa, sb, pn, qn;
  logic signed [PW-1:0] cmp_l, cmp_r;

  logic          gcd_start, gcd_done, div_start, div_done;
  logic [PW-1:0] gcd_g, div_num, div_q;

  logic          neg_fin, ovf;
  logic [PW-1:0] nval, lim;
  logic signed [W-1:0] res_num_w, res_den_w;
  logic [FIELD_BITS-1:0] res_num, res_den;
  status_t       status;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_an = in_tdata[W-1:0];
  assign in_ad = in_tdata[FIELD_BITS +: W];
  assign in_bn = in_tdata[2*FIELD_BITS +: W];
  assign in_bd = in_tdata[3*FIELD_BITS +: W];

  assign an_m = mag(an_r);
  assign ad_m = mag(ad_r);
  assign bn_m = mag(bn_r);
  assign bd_m = mag(bd_r);
  // Operand signs once denominators are made positive
  assign sa   = an_r[W-1] ^ ad_r[W-1];
  assign sb   = bn_r[W-1] ^ bd_r[W-1];

  // Select the operands of the shared multiplier
  always_comb begin
    case (state_r)
      S_MUL_P: begin
        mul_a = an_m;
        mul_b = (op_r == OP_MUL) ? bn_m : bd_m;
      end
      S_MUL_Q: begin
        mul_a = bn_m;
        mul_b = ad_m;
      end
      default: begin
        mul_a = ad_m;
        mul_b = bd_m;
      end
    endcase
  end

  assign mul_y = mul_a * mul_b;

  // Signed cross products for compares
  assign cmp_l = sa ? -$signed(p_r) : $signed(p_r);
  assign cmp_r = sb ? -$signed(mul_y) : $signed(mul_y);

  assign pn = sa && (p_r != '0);
  assign qn = (op_r == OP_SUB) ? (!sb && (q_r != '0)) : (sb && (q_r != '0));

  assign gcd_start = (state_r == S_GCD_GO);
  assign div_start = (state_r == S_DIVN_GO) || (state_r == S_DIVD_GO);
  assign div_num   = (state_r == S_DIVN_GO) ? nmag_r : dmag_r;

  // Sequence one item through multiply, gcd and divide (compares and operand errors skip ahead to output)
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    an_nxt    = an_r;
    ad_nxt    = ad_r;
    bn_nxt    = bn_r;
    bd_nxt    = bd_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    nmag_nxt  = nmag_r;
    dmag_nxt  = dmag_r;
    nneg_nxt  = nneg_r;
    truth_nxt = truth_r;
    err_nxt   = err_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = op_t'(in_tuser);
          an_nxt    = in_an;
          ad_nxt    = in_ad;
          bn_nxt    = in_bn;
          bd_nxt    = in_bd;
          nmag_nxt  = '0;
          dmag_nxt  = PW'(1);
          nneg_nxt  = 1'b0;
          truth_nxt = 1'b0;
          err_nxt   = (in_ad == '0) || (in_bd == '0) ||
                      ((op_t'(in_tuser) == OP_DIV) && (in_bn == '0));
          state_nxt = err_nxt ? S_OUT : S_MUL_P;
        end
      end
      S_MUL_P: begin
        p_nxt     = mul_y;
        state_nxt = S_MUL_Q;
      end
      S_MUL_Q: begin
        q_nxt = mul_y;
        if (op_r[2]) begin
          case (op_r)
            OP_GT:   truth_nxt = cmp_l > cmp_r;
            OP_LT:   truth_nxt = cmp_l < cmp_r;
            OP_EQ:   truth_nxt = cmp_l == cmp_r;
            default: truth_nxt = cmp_l != cmp_r;
          endcase
          state_nxt = S_OUT;
        end else if (op_r == OP_DIV) begin
          nmag_nxt  = p_r;
          dmag_nxt  = mul_y;
          nneg_nxt  = pn ^ sb;
          state_nxt = S_GCD_GO;
        end else begin
          state_nxt = S_MUL_D;
        end
      end
      S_MUL_D: begin
        dmag_nxt = mul_y;
        if (op_r == OP_MUL) begin
          nmag_nxt = p_r;
          nneg_nxt = (sa ^ sb) && (p_r != '0);
        end else if (pn == qn) begin
          nmag_nxt = p_r + q_r;
          nneg_nxt = pn;
        end else if (p_r >= q_r) begin
          nmag_nxt = p_r - q_r;
          nneg_nxt = pn;
        end else begin
          nmag_nxt = q_r - p_r;
          nneg_nxt = qn;
        end
        state_nxt = S_GCD_GO;
      end
      S_GCD_GO:   state_nxt = S_GCD_WAIT;
      S_GCD_WAIT: begin
        if (gcd_done) state_nxt = S_DIVN_GO;
      end
      S_DIVN_GO:  state_nxt = S_DIVN_WAIT;
      S_DIVN_WAIT: begin
        if (div_done) begin
          nmag_nxt  = div_q;
          state_nxt = S_DIVD_GO;
        end
      end
      S_DIVD_GO:  state_nxt = S_DIVD_WAIT;
      S_DIVD_WAIT: begin
        if (div_done) begin
          dmag_nxt  = div_q;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r    <= op_nxt;
    an_r    <= an_nxt;
    ad_r    <= ad_nxt;
    bn_r    <= bn_nxt;
    bd_r    <= bd_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    nmag_r  <= nmag_nxt;
    dmag_r  <= dmag_nxt;
    nneg_r  <= nneg_nxt;
    truth_r <= truth_nxt;
    err_r   <= err_nxt;
  end

  rau_gcd #(.PW(PW)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (nmag_r),
    .b_in  (dmag_r),
    .done  (gcd_done),
    .gcd   (gcd_g)
  );

  rau_div #(.PW(PW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (gcd_g),
    .done     (div_done),
    .quotient (div_q)
  );

  // Form result words and flag results that do not fit a word
  assign neg_fin   = nneg_r && (nmag_r != '0);
  assign nval      = neg_fin ? (~nmag_r + 1'b1) : nmag_r;
  assign lim       = PW'(1) << (W - 1);
  assign ovf       = (neg_fin ? (nmag_r > lim) : (nmag_r >= lim)) || (dmag_r >= lim);
  assign res_num_w = nval[W-1:0];
  assign res_den_w = dmag_r[W-1:0];
  assign res_num   = FIELD_BITS'(res_num_w);
  assign res_den   = FIELD_BITS'(res_den_w);
  assign status    = err_r ? ST_DIV_ZERO : (ovf ? ST_OVERFLOW : ST_OK);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {res_den, res_num};
  assign out_tuser  = {status, truth_r};

  `ASSERT_IMPLIES(a_ready_not_busy, clk, rst_n, in_tready, !out_tvalid, "ready while result held")
  `ASSERT_IMPLIES(a_err_zero_res, clk, rst_n, out_tvalid && (status == ST_DIV_ZERO), (res_num == '0) && (res_den == FIELD_BITS'(1)), "error result not 0/1")
  `ASSERT_IMPLIES(a_truth_cmp_only, clk, rst_n, out_tvalid && truth_r, op_r[2] && !err_r, "truth set for arithmetic op")
  `ASSERT_NEXT(a_gcd_start_wait, clk, rst_n, gcd_start, (state_r == S_GCD_WAIT) && !gcd_done, "gcd start not followed by wait")

endmodule
`default_nettype wire
